FILE: hdl/vphp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vphp_pkg;

	localparam int DEF_HEADER_BYTES = 34;
	localparam int DEF_NAME_BYTES   = 16;

	localparam int POS_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] OFS_TYPE    = POS_W'(4);
	localparam logic [POS_W-1:0] OFS_HLEN    = POS_W'(5);
	localparam logic [POS_W-1:0] OFS_CHAN    = POS_W'(6);
	localparam logic [POS_W-1:0] OFS_SEQ     = POS_W'(8);
	localparam logic [POS_W-1:0] OFS_NAME    = POS_W'(16);
	localparam logic [POS_W-1:0] OFS_LENGTH  = POS_W'(32);
	localparam logic [POS_W-1:0] MAGIC_BYTES = POS_W'(4);

	// "WTK1", byte i at bits 8i
	localparam logic [31:0] MAGIC_WORD = 32'h314B_5457;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_BAD_MAGIC = 2'd2,
		ST_BAD_LEN   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NAME_LOW  = 1'b0,
		CFG_NAME_HIGH = 1'b1
	} cfg_index_t;

	// one queue entry: a forwarded byte, a summary, or both
	typedef struct packed {
		logic        fwd;
		logic        sum;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [7:0]  packet_type;
		logic [15:0] channel;
		logic [31:0] sequence_res;
		logic [15:0] payload_length;
		logic        from_own_device;
	} rec_t;

	typedef struct packed {
		logic        is_summary;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [7:0]  packet_type;
		logic [15:0] channel;
		logic [31:0] sequence_res;
		logic [15:0] payload_length;
		logic        from_own_device;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

FILE: hdl/vphp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vphp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_datagram;

	modport source (output valid, output rx_byte, output end_of_datagram, input ready);
	modport sink   (input valid, input rx_byte, input end_of_datagram, output ready);
endinterface

`default_nettype wire

FILE: hdl/vphp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vphp_out_if;
	logic        valid;
	logic        ready;
	logic        is_summary;
	logic [7:0]  payload_byte;
	logic [1:0]  status;
	logic [7:0]  packet_type;
	logic [15:0] channel;
	logic [31:0] sequence_res;
	logic [15:0] payload_length;
	logic        from_own_device;

	modport source (
		output valid, output is_summary, output payload_byte, output status,
		output packet_type, output channel, output sequence_res,
		output payload_length, output from_own_device, input ready
	);
	modport sink (
		input valid, input is_summary, input payload_byte, input status,
		input packet_type, input channel, input sequence_res,
		input payload_length, input from_own_device, output ready
	);
endinterface

`default_nettype wire

FILE: hdl/voice_packet_header_parser_core.sv
// Voice datagram header parser.
// stream: one datagram byte per item, end_of_datagram set on the final byte.
// result: a forwarded payload byte (is_summary low) or the datagram summary
//   (is_summary high) with status, header captures and the own-name match.
// cfg_we/cfg_index/cfg_wdata: own device name, bytes 0-7 at index 0 and
//   bytes 8-15 at index 1; write only while the parser is idle.
// Throughput: one byte per cycle while the queue has room. A final byte that is
//   also a payload byte makes two results, which the output stage sends in turn.
// Each result is held first in a queue entry and then in the output register.
// A four-entry queue sits between the parser and the output register; stream
//   ready drops only when that queue is full, i.e. after the receiver has stalled.
// Reset clears the parser to the start of a datagram, empties the queue and
//   clears the own name to all zeros.
`timescale 1ns / 1ps
`default_nettype none

module voice_packet_header_parser_core #(
	parameter int HEADER_BYTES = vphp_pkg::DEF_HEADER_BYTES,
	parameter int NAME_BYTES   = vphp_pkg::DEF_NAME_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vphp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vphp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	vphp_in_if.sink                         stream,
	vphp_out_if.source                      result
);
	import vphp_pkg::*;

	logic    accept;
	logic    push;
	logic    pop;
	rec_t    rec;
	rec_t    head;
	q_stat_t qstat;
	res_t    res;

	assign stream.ready = !qstat.full;
	assign accept       = stream.valid && stream.ready;

	vphp_front #(
		.HEADER_BYTES (HEADER_BYTES),
		.NAME_BYTES   (NAME_BYTES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.accept          (accept),
		.rx_byte         (stream.rx_byte),
		.end_of_datagram (stream.end_of_datagram),
		.push            (push),
		.rec             (rec)
	);

	vphp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (rec),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	vphp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (qstat),
		.pop       (pop),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res       (res)
	);

	assign result.is_summary      = res.is_summary;
	assign result.payload_byte    = res.payload_byte;
	assign result.status          = res.status;
	assign result.packet_type     = res.packet_type;
	assign result.channel         = res.channel;
	assign result.sequence_res    = res.sequence_res;
	assign result.payload_length  = res.payload_length;
	assign result.from_own_device = res.from_own_device;

	a_byte_clean : assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.is_summary |->
			result.status == ST_OK && result.packet_type == '0 && result.channel == '0 &&
			result.sequence_res == '0 && result.payload_length == '0 &&
			!result.from_own_device)
		else $error("forwarded byte carries header fields");

	a_fail_clean : assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.is_summary && result.status != ST_OK |->
			result.packet_type == '0 && result.channel == '0 && result.sequence_res == '0 &&
			result.payload_length == '0 && !result.from_own_device &&
			result.payload_byte == '0)
		else $error("failed summary carries captures");

	a_last_queued : assert property (@(posedge clk) disable iff (!arst_n)
		accept && stream.end_of_datagram |=> !qstat.empty)
		else $error("final byte left no summary in the queue");

	a_pop_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty || !push)
		else $error("pop from an empty queue");

endmodule

`default_nettype wire

FILE: hdl/vphp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vphp_front #(
	parameter int HEADER_BYTES = vphp_pkg::DEF_HEADER_BYTES,
	parameter int NAME_BYTES   = vphp_pkg::DEF_NAME_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vphp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vphp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            accept,
	input  logic [7:0]                      rx_byte,
	input  logic                            end_of_datagram,
	output logic                            push,
	output vphp_pkg::rec_t                  rec
);
	import vphp_pkg::*;

	localparam logic [POS_W-1:0] HdrPos   = HEADER_BYTES[POS_W-1:0];
	localparam logic [POS_W:0]   HdrExt   = HEADER_BYTES[POS_W:0];
	localparam logic [7:0]       HdrByte  = HEADER_BYTES[7:0];
	localparam logic [POS_W-1:0] NameStop = OFS_NAME + NAME_BYTES[POS_W-1:0];

	logic [CFG_DATA_W-1:0] own_name_low_q, own_name_high_q;

	logic [POS_W-1:0] pos_q, pos_d;
	logic             magic_q, magic_d;
	logic [7:0]       hlen_q, hlen_d;
	logic [7:0]       type_q, type_d;
	logic [15:0]      chan_q, chan_d;
	logic [31:0]      seq_q, seq_d;
	logic [15:0]      len_q, len_d;
	logic             mismatch_q, mismatch_d;
	logic             ended_q, ended_d;

	logic [2*CFG_DATA_W-1:0] own_name;
	logic [7:0]              own_byte;
	logic                    in_name;
	logic                    fwd;
	status_t                 status;

	assign own_name = {own_name_high_q, own_name_low_q};
	assign own_byte = own_name[{pos_q[3:0], 3'b000} +: 8];
	assign in_name  = (pos_q >= OFS_NAME) && (pos_q < NameStop);

	always_comb begin
		magic_d    = magic_q;
		hlen_d     = hlen_q;
		type_d     = type_q;
		chan_d     = chan_q;
		seq_d      = seq_q;
		len_d      = len_q;
		mismatch_d = mismatch_q;
		ended_d    = ended_q;

		if (pos_q < MAGIC_BYTES) begin
			if (rx_byte != MAGIC_WORD[{pos_q[1:0], 3'b000} +: 8])
				magic_d = 1'b0;
		end else if (pos_q == OFS_TYPE) begin
			type_d = rx_byte;
		end else if (pos_q == OFS_HLEN) begin
			hlen_d = rx_byte;
		end else if (pos_q == OFS_CHAN) begin
			chan_d[7:0] = rx_byte;
		end else if (pos_q == OFS_CHAN + POS_W'(1)) begin
			chan_d[15:8] = rx_byte;
		end else if (pos_q >= OFS_SEQ && pos_q < OFS_SEQ + POS_W'(4)) begin
			seq_d[{pos_q[1:0], 3'b000} +: 8] = rx_byte;
		end else if (pos_q == OFS_LENGTH) begin
			len_d[7:0] = rx_byte;
		end else if (pos_q == OFS_LENGTH + POS_W'(1)) begin
			len_d[15:8] = rx_byte;
		end

		// strncmp: stop at the first difference or at a shared terminator
		if (in_name && !ended_q && !mismatch_q) begin
			if (rx_byte != own_byte)
				mismatch_d = 1'b1;
			else if (rx_byte == 8'd0)
				ended_d = 1'b1;
		end

		// count saturates; the same value is the datagram length on the last byte
		pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);

		fwd = (pos_q != POS_MAX) && (pos_q >= HdrPos) && magic_q && (hlen_q == HdrByte) &&
			({1'b0, pos_q} < HdrExt + {1'b0, len_q});

		if (pos_d < HdrPos)
			status = ST_TOO_SHORT;
		else if (!magic_d)
			status = ST_BAD_MAGIC;
		else if (hlen_d != HdrByte || {1'b0, pos_d} < HdrExt + {1'b0, len_d})
			status = ST_BAD_LEN;
		else
			status = ST_OK;

		rec                 = '0;
		rec.fwd             = fwd;
		rec.sum             = end_of_datagram;
		rec.payload_byte    = rx_byte;
		rec.status          = status;
		if (status == ST_OK) begin
			rec.packet_type     = type_d;
			rec.channel         = chan_d;
			rec.sequence_res    = seq_d;
			rec.payload_length  = len_d;
			rec.from_own_device = !mismatch_d;
		end
	end

	assign push = accept && (fwd || end_of_datagram);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_name_low_q  <= '0;
			own_name_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_NAME_LOW:  own_name_low_q  <= cfg_wdata;
				CFG_NAME_HIGH: own_name_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			magic_q    <= 1'b1;
			hlen_q     <= '0;
			type_q     <= '0;
			chan_q     <= '0;
			seq_q      <= '0;
			len_q      <= '0;
			mismatch_q <= 1'b0;
			ended_q    <= 1'b0;
		end else if (accept) begin
			if (end_of_datagram) begin
				// back to a clean parser for the next datagram
				pos_q      <= '0;
				magic_q    <= 1'b1;
				hlen_q     <= '0;
				type_q     <= '0;
				chan_q     <= '0;
				seq_q      <= '0;
				len_q      <= '0;
				mismatch_q <= 1'b0;
				ended_q    <= 1'b0;
			end else begin
				pos_q      <= pos_d;
				magic_q    <= magic_d;
				hlen_q     <= hlen_d;
				type_q     <= type_d;
				chan_q     <= chan_d;
				seq_q      <= seq_d;
				len_q      <= len_d;
				mismatch_q <= mismatch_d;
				ended_q    <= ended_d;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/vphp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vphp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vphp_pkg::rec_t    wdata,
	input  logic              pop,
	output vphp_pkg::rec_t    head,
	output vphp_pkg::q_stat_t stat
);
	import vphp_pkg::*;

	rec_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: hdl/vphp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module vphp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  vphp_pkg::rec_t    head,
	input  vphp_pkg::q_stat_t stat,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output vphp_pkg::res_t    res
);
	import vphp_pkg::*;

	logic res_valid_q;
	logic phase_q;
	res_t res_q;
	res_t res_d;
	logic load;
	logic emit_byte;

	assign load      = !res_valid_q || res_ready;
	// a datagram ending inside the payload gives the byte first, then the summary
	assign emit_byte = head.fwd && !phase_q;
	assign pop       = load && !stat.empty && !(emit_byte && head.sum);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		res_d = '0;
		if (emit_byte) begin
			res_d.payload_byte = head.payload_byte;
		end else begin
			res_d.is_summary      = 1'b1;
			res_d.status          = head.status;
			res_d.packet_type     = head.packet_type;
			res_d.channel         = head.channel;
			res_d.sequence_res    = head.sequence_res;
			res_d.payload_length  = head.payload_length;
			res_d.from_own_device = head.from_own_device;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			res_valid_q <= !stat.empty;
			if (!stat.empty)
				phase_q <= emit_byte && head.sum;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !stat.empty)
			res_q <= res_d;
	end

endmodule

`default_nettype wire
